### rtl/rotary_encoder_parameter_editor_defines.svh
// ----------------------------------------------------------------------------
// Rotary encoder parameter editor: assertion macros
// Shared assertion wrappers. They check on the rising edge of clock and are
// held off while reset is high. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_PARAMETER_EDITOR_DEFINES_SVH
`define ROTARY_ENCODER_PARAMETER_EDITOR_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge out of reset.
`define REP_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("rep assertion failed");

// When the first condition holds, the second must hold in the next cycle.
`define REP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rep assertion failed");

`else

`define REP_ASSERT_ALWAYS(lbl, cond)
`define REP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/rep_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder parameter editor package
// Widths, table geometry, reset values, register indexes and shared types.
// ----------------------------------------------------------------------------
package rep_pkg;

   // Table geometry.
   localparam int NUM_ENTRIES      = 11;
   localparam int EDITABLE_ENTRIES = 7;
   localparam int NUM_DEFAULTS     = 7;

   // Field widths.
   localparam int IDX_W   = 4;
   localparam int VAL_W   = 9;
   localparam int SLOT_W  = 2;
   localparam int CFG_W   = 8;
   localparam int CNT_W   = 9;
   localparam int DUTY_W  = 17;
   localparam int CSR_A_W = 8;

   // Register reset values.
   localparam logic [CFG_W-1:0]        OFF_DELAY_RST    = 8'd100;
   localparam logic [CFG_W-1:0]        VALUE_MAX_RST    = 8'hff;
   localparam logic signed [CFG_W-1:0] SPECIAL_MIN_RST  = -8'sd128;
   localparam logic [IDX_W-1:0]        SPECIAL_SLOT_RST = 4'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_A_W-1:0] {
      CSR_OFF_DELAY    = 8'd0,
      CSR_VALUE_MAX    = 8'd1,
      CSR_SPECIAL_MIN  = 8'd2,
      CSR_SPECIAL_SLOT = 8'd3
   } csr_index_type;

   // One input word as held in the input register.
   typedef struct packed {
      logic                    enc_a;
      logic                    enc_b;
      logic                    button;
      logic                    pump_idle;
      logic                    scan_done;
      logic                    meas_valid;
      logic [SLOT_W-1:0]       meas_slot;
      logic signed [VAL_W-1:0] meas_value;
   } req_item_type;

   // Events decoded from the filtered encoder and the button.
   typedef struct packed {
      logic step;
      logic cw;
      logic release_btn;
   } enc_event_type;

   // Write request into the value table.
   typedef struct packed {
      logic                    en;
      logic [IDX_W-1:0]        addr;
      logic signed [VAL_W-1:0] data;
   } tbl_write_type;

   // Reset content of one table entry.
   function automatic logic signed [VAL_W-1:0] default_value(input int idx);
      logic signed [VAL_W-1:0] val;
      val = '0;
      case (idx)
         0: val = 9'sd100;
         1: val = 9'sd0;
         2: val = 9'sd20;
         3: val = 9'sd4;
         4: val = 9'sd0;
         5: val = 9'sd0;
         6: val = 9'sd64;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/rep_encoder_filter.sv
// ----------------------------------------------------------------------------
// Encoder and button front end
// Debounces A and B (two equal samples), detects a rising filtered A as a
// step and a high-to-low button level as a release.
// ----------------------------------------------------------------------------
module rep_encoder_filter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   enc_a,
   input  logic                   enc_b,
   input  logic                   button,
   output rep_pkg::enc_event_type events
);

   logic a_last_ff, a_last_in;
   logic a_filt_ff, a_filt_in;
   logic a_old_ff, a_old_in;
   logic b_last_ff, b_last_in;
   logic b_filt_ff, b_filt_in;
   logic btn_last_ff, btn_last_in;

   // Filtered copies take the raw level when two samples agree.
   always_comb begin
      a_filt_in   = (enc_a == a_last_ff) ? enc_a : a_filt_ff;
      b_filt_in   = (enc_b == b_last_ff) ? enc_b : b_filt_ff;
      a_last_in   = enc_a;
      b_last_in   = enc_b;
      a_old_in    = a_filt_in;
      btn_last_in = button;
   end

   // Event decode from the freshly filtered encoder levels and the raw button.
   always_comb begin
      events.step        = a_filt_in & ~a_old_ff;
      events.cw          = ~b_filt_in;
      events.release_btn = ~button & btn_last_ff;
   end

   // Filter state moves only when a word is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_last_ff   <= 1'b0;
         a_filt_ff   <= 1'b0;
         a_old_ff    <= 1'b0;
         b_last_ff   <= 1'b0;
         b_filt_ff   <= 1'b0;
         btn_last_ff <= 1'b0;
      end else if (advance) begin
         a_last_ff   <= a_last_in;
         a_filt_ff   <= a_filt_in;
         a_old_ff    <= a_old_in;
         b_last_ff   <= b_last_in;
         b_filt_ff   <= b_filt_in;
         btn_last_ff <= btn_last_in;
      end
   end

endmodule

### rtl/rep_value_table.sv
// ----------------------------------------------------------------------------
// Value table
// Register file of parameter and measurement entries with two write ports
// and one read port. The read sees a measurement write of the same word.
// ----------------------------------------------------------------------------
module rep_value_table (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  rep_pkg::tbl_write_type                 meas_wr,
   input  rep_pkg::tbl_write_type                 save_wr,
   input  logic [rep_pkg::IDX_W-1:0]              rd_addr,
   output logic signed [rep_pkg::VAL_W-1:0]       rd_data
);

   logic signed [rep_pkg::VAL_W-1:0] vals_ff [rep_pkg::NUM_ENTRIES];
   logic                             rd_in_range;
   logic signed [rep_pkg::VAL_W-1:0] rd_raw;

   // Read with bypass of the measurement write only; a save to the read
   // address in the same word is not bypassed.
   always_comb begin
      rd_in_range = (32'(rd_addr) < rep_pkg::NUM_ENTRIES);
      rd_raw      = rd_in_range ? vals_ff[rd_addr] : '0;
      if (meas_wr.en && (meas_wr.addr == rd_addr)) begin
         rd_data = meas_wr.data;
      end else begin
         rd_data = rd_raw;
      end
   end

   // Entry registers, loaded with the defaults at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rep_pkg::NUM_ENTRIES; i++) begin
            vals_ff[i] <= rep_pkg::default_value(i);
         end
      end else if (advance) begin
         for (int i = 0; i < rep_pkg::NUM_ENTRIES; i++) begin
            if (meas_wr.en && (32'(meas_wr.addr) == i)) begin
               vals_ff[i] <= meas_wr.data;
            end else if (save_wr.en && (32'(save_wr.addr) == i)) begin
               vals_ff[i] <= save_wr.data;
            end
         end
      end
   end

endmodule

### rtl/rep_pump_delay.sv
// ----------------------------------------------------------------------------
// Pump-off delay
// Servo enable rises while the pump runs and drops on the first idle tick
// past the configured number of idle ticks.
// ----------------------------------------------------------------------------
module rep_pump_delay (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      pump_idle,
   input  logic [rep_pkg::CFG_W-1:0] off_delay,
   output logic                      enable_next
);

   logic                      enable_ff, enable_in;
   logic [rep_pkg::CNT_W-1:0] count_ff, count_in;
   logic [rep_pkg::CNT_W-1:0] count_inc;

   // Count idle ticks while enabled; clear on a running pump or on expiry.
   always_comb begin
      count_inc = count_ff + 1'b1;
      enable_in = enable_ff;
      count_in  = count_ff;
      if (!pump_idle) begin
         enable_in = 1'b1;
         count_in  = '0;
      end else if (enable_ff) begin
         if (count_inc > {1'b0, off_delay}) begin
            enable_in = 1'b0;
            count_in  = '0;
         end else begin
            count_in = count_inc;
         end
      end
      enable_next = enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
      end else if (advance) begin
         enable_ff <= enable_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/rotary_encoder_parameter_editor.sv
// ----------------------------------------------------------------------------
// Rotary encoder parameter editor
// A word accepted on req_ reaches rsp_ via the input and result registers.
// Throughput: one word per cycle while rsp_ready is high, set by the single
// pass from the input register through the menu logic into the result register.
// Reset: synchronous and active high; the table returns to its defaults and
// the configuration registers to their reset values, with no clearing pass.
// ----------------------------------------------------------------------------
`include "rotary_encoder_parameter_editor_defines.svh"

module rotary_encoder_parameter_editor (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_enc_a,
   input  logic                                  req_enc_b,
   input  logic                                  req_button,
   input  logic                                  req_pump_idle,
   input  logic                                  req_scan_done,
   input  logic                                  req_meas_valid,
   input  logic [rep_pkg::SLOT_W-1:0]            req_meas_slot,
   input  logic signed [rep_pkg::VAL_W-1:0]      req_meas_value,
   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rep_pkg::VAL_W-1:0]      rsp_shown_value,
   output logic [rep_pkg::IDX_W-1:0]             rsp_selected_index,
   output logic                                  rsp_editing,
   output logic                                  rsp_redraw_pulse,
   output logic                                  rsp_save_pulse,
   output logic                                  rsp_refresh_pulse,
   output logic                                  rsp_servo_enable,
   output logic signed [rep_pkg::DUTY_W-1:0]     rsp_duty_word,
   // Configuration port.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rep_pkg::CSR_A_W-1:0]           csr_index,
   input  logic [rep_pkg::CFG_W-1:0]             csr_wdata
);

   // Configuration registers.
   logic [rep_pkg::CFG_W-1:0]        off_delay_ff;
   logic [rep_pkg::CFG_W-1:0]        value_max_ff;
   logic signed [rep_pkg::CFG_W-1:0] special_min_ff;
   logic [rep_pkg::IDX_W-1:0]        special_slot_ff;

   // Input register.
   logic                  in_valid_ff, in_valid_in;
   rep_pkg::req_item_type in_item_ff, in_item_in;

   // Menu state.
   logic [rep_pkg::IDX_W-1:0]        cur_index_ff, cur_index_in;
   logic signed [rep_pkg::VAL_W-1:0] cur_value_ff, cur_value_in;
   logic                             edit_ff, edit_in;
   logic                             scan_pend_ff, scan_pend_in;

   // Result register.
   logic                              out_valid_ff, out_valid_in;
   logic signed [rep_pkg::VAL_W-1:0]  out_value_ff;
   logic [rep_pkg::IDX_W-1:0]         out_index_ff;
   logic                              out_edit_ff;
   logic                              out_redraw_ff, out_redraw_in;
   logic                              out_save_ff, out_save_in;
   logic                              out_refresh_ff, out_refresh_in;
   logic                              out_servo_ff;

   // Datapath signals.
   logic                             advance;
   rep_pkg::enc_event_type           events;
   rep_pkg::tbl_write_type           meas_wr;
   rep_pkg::tbl_write_type           save_wr;
   logic [rep_pkg::IDX_W:0]          meas_dst;
   logic [rep_pkg::IDX_W-1:0]        rd_addr;
   logic [rep_pkg::IDX_W-1:0]        next_index;
   logic signed [rep_pkg::VAL_W-1:0] rd_data;
   logic signed [rep_pkg::VAL_W-1:0] low_limit;
   logic signed [rep_pkg::VAL_W-1:0] high_limit;
   logic                             toggle;
   logic                             scan_seen;
   logic                             servo_next;
   logic                             idx_last;
   logic                             idx_first;

   // Handshake: the input register moves into the result register whenever
   // the result register is empty or being drained.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = req_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      in_item_in.enc_a      = req_enc_a;
      in_item_in.enc_b      = req_enc_b;
      in_item_in.button     = req_button;
      in_item_in.pump_idle  = req_pump_idle;
      in_item_in.scan_done  = req_scan_done;
      in_item_in.meas_valid = req_meas_valid;
      in_item_in.meas_slot  = req_meas_slot;
      in_item_in.meas_value = req_meas_value;
      csr_ready = 1'b1;
   end

   rep_encoder_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .enc_a   (in_item_ff.enc_a),
      .enc_b   (in_item_ff.enc_b),
      .button  (in_item_ff.button),
      .events  (events)
   );

   rep_pump_delay u_pump (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .pump_idle   (in_item_ff.pump_idle),
      .off_delay   (off_delay_ff),
      .enable_next (servo_next)
   );

   rep_value_table u_table (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .meas_wr (meas_wr),
      .save_wr (save_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Measurement write lands after the editable entries.
   always_comb begin
      meas_dst     = (rep_pkg::IDX_W+1)'(rep_pkg::EDITABLE_ENTRIES)
                     + (rep_pkg::IDX_W+1)'(in_item_ff.meas_slot);
      meas_wr.en   = in_item_ff.meas_valid
                     && (32'(meas_dst) < rep_pkg::NUM_ENTRIES);
      meas_wr.addr = meas_dst[rep_pkg::IDX_W-1:0];
      meas_wr.data = in_item_ff.meas_value;
   end

   // Button release toggles edit mode on an editable entry; leaving edit
   // mode stores the value back.
   always_comb begin
      toggle       = !events.step && events.release_btn
                     && (32'(cur_index_ff) < rep_pkg::EDITABLE_ENTRIES);
      save_wr.en   = toggle && edit_ff;
      save_wr.addr = cur_index_ff;
      save_wr.data = cur_value_ff;
   end

   // Browse target with wrap in both directions.
   always_comb begin
      idx_last  = (32'(cur_index_ff) >= rep_pkg::NUM_ENTRIES - 1);
      idx_first = (cur_index_ff == '0)
                  || (32'(cur_index_ff) >= rep_pkg::NUM_ENTRIES);
      if (events.cw) begin
         next_index = idx_last ? '0 : cur_index_ff + 1'b1;
      end else begin
         next_index = idx_first ? rep_pkg::IDX_W'(rep_pkg::NUM_ENTRIES - 1)
                                : cur_index_ff - 1'b1;
      end
      rd_addr = events.step ? next_index : cur_index_ff;
   end

   // Edit limits.
   always_comb begin
      high_limit = $signed({1'b0, value_max_ff});
      low_limit  = (cur_index_ff == special_slot_ff)
                   ? $signed({special_min_ff[rep_pkg::CFG_W-1], special_min_ff})
                   : '0;
   end

   // Menu update: a step wins over the button and over a pending scan.
   always_comb begin
      scan_seen      = scan_pend_ff || in_item_ff.scan_done;
      cur_index_in   = cur_index_ff;
      cur_value_in   = cur_value_ff;
      edit_in        = edit_ff ^ toggle;
      scan_pend_in   = scan_seen;
      out_redraw_in  = events.step;
      out_save_in    = toggle;
      out_refresh_in = 1'b0;
      if (events.step) begin
         if (edit_ff) begin
            if (events.cw) begin
               if (cur_value_ff < high_limit) begin
                  cur_value_in = cur_value_ff + 9'sd1;
               end
            end else if (cur_value_ff > low_limit) begin
               cur_value_in = cur_value_ff - 9'sd1;
            end
         end else begin
            cur_index_in = next_index;
            cur_value_in = rd_data;
         end
      end else if (scan_seen) begin
         scan_pend_in = 1'b0;
         if (32'(cur_index_ff) >= rep_pkg::EDITABLE_ENTRIES) begin
            cur_value_in   = rd_data;
            out_refresh_in = 1'b1;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_delay_ff    <= rep_pkg::OFF_DELAY_RST;
         value_max_ff    <= rep_pkg::VALUE_MAX_RST;
         special_min_ff  <= rep_pkg::SPECIAL_MIN_RST;
         special_slot_ff <= rep_pkg::SPECIAL_SLOT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rep_pkg::CSR_OFF_DELAY:    off_delay_ff    <= csr_wdata;
            rep_pkg::CSR_VALUE_MAX:    value_max_ff    <= csr_wdata;
            rep_pkg::CSR_SPECIAL_MIN:  special_min_ff  <= $signed(csr_wdata);
            rep_pkg::CSR_SPECIAL_SLOT: special_slot_ff <= csr_wdata[rep_pkg::IDX_W-1:0];
            default: ;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cur_index_ff <= '0;
         cur_value_ff <= rep_pkg::default_value(0);
         edit_ff      <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cur_index_ff <= cur_index_in;
            cur_value_ff <= cur_value_in;
            edit_ff      <= edit_in;
            scan_pend_ff <= scan_pend_in;
         end
      end
   end

   // Input word and result word registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_value_ff   <= cur_value_in;
         out_index_ff   <= cur_index_in;
         out_edit_ff    <= edit_in;
         out_redraw_ff  <= out_redraw_in;
         out_save_ff    <= out_save_in;
         out_refresh_ff <= out_refresh_in;
         out_servo_ff   <= servo_next;
      end
   end

   // Result ports; the duty word is the shown value shifted up a byte, plus one.
   always_comb begin
      rsp_valid          = out_valid_ff;
      rsp_shown_value    = out_value_ff;
      rsp_selected_index = out_index_ff;
      rsp_editing        = out_edit_ff;
      rsp_redraw_pulse   = out_redraw_ff;
      rsp_save_pulse     = out_save_ff;
      rsp_refresh_pulse  = out_refresh_ff;
      rsp_servo_enable   = out_servo_ff;
      rsp_duty_word      = $signed({out_value_ff, 8'h01});
   end

   // Assertions.
   `REP_ASSERT_ALWAYS(a_step_excludes_save, !(out_valid_ff && out_redraw_ff && out_save_ff))
   `REP_ASSERT_ALWAYS(a_step_excludes_refresh, !(out_valid_ff && out_redraw_ff && out_refresh_ff))
   `REP_ASSERT_ALWAYS(a_edit_on_editable, !(edit_ff && (32'(cur_index_ff) >= rep_pkg::EDITABLE_ENTRIES)))
   `REP_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_ff)

endmodule
